// ----- src/tcw_pkg.sv -----
// Package for the text console writer: command codes, control characters
// and cell constants shared by the top level and its checker.
// Depends on nothing.
package tcw_pkg;

   localparam int CMD_W = 3;

   localparam logic [CMD_W-1:0] CMD_PUT_CHAR = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUT_AT   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_CUR  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] BLANK_CHAR = 8'h20;
   localparam logic [7:0] RESET_ATTR = 8'h07;

   typedef logic [15:0] cell_type;

endpackage

// ----- src/text_console_writer_unit.sv -----
// Text console writer top level: cursor control, command decode and the
// sweeps for reset, clear and scroll. Depends on tcw_pkg and tcw_ram.
//
// A request is taken when start is high and busy is low; its result appears
// on the rsp_ ports for one cycle, marked by rsp_strobe, and cannot be held
// off. Put character, put at position, set cursor, read cell and the unused
// codes answer in the cycle after acceptance, and a new request may be taken
// in that same cycle, so these run at one request per cycle. The rate is set
// by the cell memory, which takes one write and one read per cycle. Clear
// writes every cell once while holding busy and answers in the first cycle
// with busy low; a put character that passes the bottom row copies the
// screen up one cell per cycle while holding busy and answers in the first
// cycle with busy low. After reset a clearing pass blanks the memory while
// busy is high; csr_ writes are taken throughout.
module text_console_writer_unit
   import tcw_pkg::*;
#(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_cell_attr,
   input  logic [6:0]  req_col,
   input  logic [4:0]  req_row,
   output logic        rsp_strobe,
   output logic [6:0]  rsp_cur_col,
   output logic [4:0]  rsp_cur_row,
   output logic [10:0] rsp_cursor_pos,
   output logic [15:0] rsp_read_cell,
   output logic        rsp_scrolled,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int MOVE  = CELLS - SCREEN_COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CNTW  = $clog2(CELLS + 1);
   localparam int CW    = $clog2(SCREEN_COLUMNS);
   localparam int RW    = $clog2(SCREEN_ROWS);

   localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
   localparam logic [CW:0]   COLS_W   = (CW+1)'(SCREEN_COLUMNS);
   localparam logic [RW:0]   ROWS_W   = (RW+1)'(SCREEN_ROWS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_FILL   = 2'd1;
   localparam logic [1:0] ST_SCROLL = 2'd2;

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                               input logic [RW-1:0] r);
      cell_addr = AW'(int'(r) * SCREEN_COLUMNS + int'(c));
   endfunction

   logic [1:0]      state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0]   cur_col_ff, cur_col_in;
   logic [RW-1:0]   cur_row_ff, cur_row_in;
   logic [7:0]      attr_ff;
   cell_type        fill_ff, fill_in;
   logic            fill_rsp_ff, fill_rsp_in;

   logic            strobe_ff, strobe_in;
   logic            rsp_rd_ff, rsp_rd_in;
   logic [CW-1:0]   rsp_col_ff, rsp_col_in;
   logic [RW-1:0]   rsp_row_ff, rsp_row_in;
   logic [AW-1:0]   rsp_pos_ff, rsp_pos_in;
   logic            rsp_scr_ff, rsp_scr_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   cell_type        wr_data;
   logic [AW-1:0]   rd_addr;
   cell_type        rd_data;

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      logic          accept;
      logic [CW-1:0] req_c;
      logic [RW-1:0] req_r;
      logic [AW-1:0] req_addr;
      logic [CW-1:0] nc;
      logic [RW:0]   nr_ext;
      logic [RW-1:0] nr;
      logic [CW:0]   col_sum;
      logic          scroll;
      cell_type      blank;
      logic [CNTW-1:0] cnt_prev;

      accept   = start && (state_ff == ST_IDLE);
      req_c    = ({1'b0, req_col} >= 8'(SCREEN_COLUMNS)) ? LAST_COL : CW'(req_col);
      req_r    = ({3'b0, req_row} >= 8'(SCREEN_ROWS)) ? LAST_ROW : RW'(req_row);
      req_addr = cell_addr(req_c, req_r);
      blank    = {attr_ff, BLANK_CHAR};
      cnt_prev = cnt_ff - CNTW'(1);

      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      fill_in     = fill_ff;
      fill_rsp_in = fill_rsp_ff;
      strobe_in   = 1'b0;
      rsp_rd_in   = 1'b0;
      rsp_col_in  = rsp_col_ff;
      rsp_row_in  = rsp_row_ff;
      rsp_pos_in  = rsp_pos_ff;
      rsp_scr_in  = rsp_scr_ff;
      wr_en       = 1'b0;
      wr_addr     = req_addr;
      wr_data     = {req_cell_attr, req_char_code};
      rd_addr     = req_addr;

      // Put character: work out the next cursor and the cell to write.
      nc      = cur_col_ff;
      nr_ext  = {1'b0, cur_row_ff};
      col_sum = {1'b0, cur_col_ff} + (CW+1)'(1);
      case (req_char_code)
         CHAR_NL: begin
            nc     = '0;
            nr_ext = {1'b0, cur_row_ff} + (RW+1)'(1);
         end
         CHAR_CR: begin
            nc = '0;
         end
         CHAR_TAB: begin
            col_sum = ({1'b0, cur_col_ff} + (CW+1)'(4)) & ~((CW+1)'(3));
            if (col_sum >= COLS_W) begin
               nc     = '0;
               nr_ext = {1'b0, cur_row_ff} + (RW+1)'(1);
            end else begin
               nc = col_sum[CW-1:0];
            end
         end
         CHAR_BS: begin
            if (cur_col_ff != '0) begin
               nc = cur_col_ff - CW'(1);
            end else if (cur_row_ff != '0) begin
               nc     = LAST_COL;
               nr_ext = {1'b0, cur_row_ff} - (RW+1)'(1);
            end
         end
         default: begin
            if (col_sum >= COLS_W) begin
               nc     = '0;
               nr_ext = {1'b0, cur_row_ff} + (RW+1)'(1);
            end else begin
               nc = col_sum[CW-1:0];
            end
         end
      endcase
      scroll = (nr_ext >= ROWS_W);
      nr     = scroll ? LAST_ROW : nr_ext[RW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_scr_in = 1'b0;
               case (req_cmd)
                  CMD_PUT_CHAR: begin
                     cur_col_in = nc;
                     cur_row_in = nr;
                     rsp_scr_in = scroll;
                     if (req_char_code == CHAR_BS) begin
                        wr_en   = 1'b1;
                        wr_addr = cell_addr(nc, nr);
                        wr_data = blank;
                     end else if (req_char_code != CHAR_NL && req_char_code != CHAR_CR &&
                                  req_char_code != CHAR_TAB) begin
                        wr_en   = 1'b1;
                        wr_addr = cell_addr(cur_col_ff, cur_row_ff);
                        wr_data = {attr_ff, req_char_code};
                     end
                     if (scroll) begin
                        state_in = ST_SCROLL;
                        cnt_in   = '0;
                     end else begin
                        strobe_in = 1'b1;
                     end
                  end
                  CMD_PUT_AT: begin
                     wr_en     = 1'b1;
                     strobe_in = 1'b1;
                  end
                  CMD_CLEAR: begin
                     cur_col_in  = '0;
                     cur_row_in  = '0;
                     fill_in     = blank;
                     fill_rsp_in = 1'b1;
                     state_in    = ST_FILL;
                     cnt_in      = '0;
                  end
                  CMD_SET_CUR: begin
                     cur_col_in = req_c;
                     cur_row_in = req_r;
                     strobe_in  = 1'b1;
                  end
                  CMD_READ: begin
                     rsp_rd_in = 1'b1;
                     strobe_in = 1'b1;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
               rsp_col_in = cur_col_in;
               rsp_row_in = cur_row_in;
               rsp_pos_in = cell_addr(cur_col_in, cur_row_in);
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[AW-1:0];
            wr_data = fill_ff;
            if (cnt_ff == CNTW'(CELLS - 1)) begin
               state_in  = ST_IDLE;
               strobe_in = fill_rsp_ff;
            end else begin
               cnt_in = cnt_ff + CNTW'(1);
            end
         end
         ST_SCROLL: begin
            // Read one row ahead; the data lands in the next cycle and is written
            // one row up. The last row is blanked once the copy runs out.
            rd_addr = (cnt_ff < CNTW'(MOVE)) ? AW'(cnt_ff + CNTW'(SCREEN_COLUMNS)) : '0;
            if (cnt_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = cnt_prev[AW-1:0];
               wr_data = (cnt_ff <= CNTW'(MOVE)) ? rd_data : blank;
            end
            if (cnt_ff == CNTW'(CELLS)) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + CNTW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_FILL;
         cnt_ff      <= '0;
         cur_col_ff  <= '0;
         cur_row_ff  <= '0;
         attr_ff     <= RESET_ATTR;
         fill_ff     <= {RESET_ATTR, BLANK_CHAR};
         fill_rsp_ff <= 1'b0;
         strobe_ff   <= 1'b0;
         rsp_rd_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         cur_col_ff  <= cur_col_in;
         cur_row_ff  <= cur_row_in;
         fill_ff     <= fill_in;
         fill_rsp_ff <= fill_rsp_in;
         strobe_ff   <= strobe_in;
         rsp_rd_ff   <= rsp_rd_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_col_ff <= rsp_col_in;
      rsp_row_ff <= rsp_row_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_scr_ff <= rsp_scr_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_cur_col    = 7'(rsp_col_ff);
   assign rsp_cur_row    = 5'(rsp_row_ff);
   assign rsp_cursor_pos = 11'(rsp_pos_ff);
   assign rsp_read_cell  = rsp_rd_ff ? rd_data : 16'h0000;
   assign rsp_scrolled   = rsp_scr_ff;

endmodule

// ----- src/tcw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on nothing.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/tcw_checker.sv -----
// Port-level checker for the text console writer and the bind that attaches
// it to the top level. Depends on tcw_pkg.
module tcw_checker
   import tcw_pkg::*;
#(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_cmd,
   input logic        rsp_strobe,
   input logic [6:0]  rsp_cur_col,
   input logic [4:0]  rsp_cur_row,
   input logic [10:0] rsp_cursor_pos,
   input logic [15:0] rsp_read_cell,
   input logic        rsp_scrolled
);

   // Position checks only make sense where the fields are wide enough.
   localparam logic FITS = (SCREEN_COLUMNS <= 128) && (SCREEN_ROWS <= 32) &&
                           (SCREEN_COLUMNS * SCREEN_ROWS <= 2048);

   logic accept;
   assign accept = start && !busy;

   // Commands other than put character and clear answer in the very next cycle.
   a_quick_answer: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd != CMD_PUT_CHAR && req_cmd != CMD_CLEAR |=> rsp_strobe)
      else $error("request without a sweep was not answered in the next cycle");

   // A clear always starts a sweep of the cell store.
   a_clear_sweeps: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_CLEAR |=> busy && !rsp_strobe)
      else $error("clear request did not start a sweep");

   a_pos_consistent: assert property (@(posedge clock) disable iff (reset)
      FITS && rsp_strobe |->
         rsp_cursor_pos == 11'(int'(rsp_cur_row) * SCREEN_COLUMNS + int'(rsp_cur_col)))
      else $error("linear cursor position disagrees with column and row");

   a_scroll_last_row: assert property (@(posedge clock) disable iff (reset)
      FITS && rsp_strobe && rsp_scrolled |-> rsp_cur_row == 5'(SCREEN_ROWS - 1))
      else $error("scrolled result does not leave the cursor on the last row");

   a_read_only_on_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_read_cell != 16'h0000 |-> rsp_strobe)
      else $error("cell data shown outside a result");

endmodule

bind text_console_writer_unit tcw_checker #(
   .SCREEN_COLUMNS (SCREEN_COLUMNS),
   .SCREEN_ROWS    (SCREEN_ROWS)
) u_tcw_checker (.*);

// ----- sim/tb_text_console_writer_unit.sv -----
// Self-checking testbench for text_console_writer_unit: directed and random requests,
// with a request-level prediction of cursor, cell store and scroll behaviour.
// Depends on tcw_pkg and the text_console_writer_unit RTL.
module tb_text_console_writer_unit
   import tcw_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS            = 80;
   localparam int ROWS            = 25;
   localparam int CELL_COUNT      = COLS * ROWS;
   localparam int WATCHDOG_CYCLES = 10000;
   localparam int SETTLE_CYCLES   = 20;

   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] ch;
      logic [7:0] attr;
      logic [6:0] col;
      logic [4:0] row;
   } console_req_type;

   typedef struct packed {
      logic [6:0]  cur_col;
      logic [4:0]  cur_row;
      logic [10:0] pos;
      logic [15:0] read_cell;
      logic        scrolled;
   } cursor_report_type;

   bit          clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        start         = 1'b0;
   logic [2:0]  req_cmd       = '0;
   logic [7:0]  req_char_code = '0;
   logic [7:0]  req_cell_attr = '0;
   logic [6:0]  req_col       = '0;
   logic [4:0]  req_row       = '0;
   logic        csr_wr_en     = 1'b0;
   logic [7:0]  csr_wr_data   = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [6:0]  rsp_cur_col;
   logic [4:0]  rsp_cur_row;
   logic [10:0] rsp_cursor_pos;
   logic [15:0] rsp_read_cell;
   logic        rsp_scrolled;

   // Predicted console state
   cell_type   screen_cells [CELL_COUNT];
   int         model_col;
   int         cursor_line;
   logic [7:0] attr_model;

   cursor_report_type pending_cursor_reports [$];

   int mismatch_count = 0;
   int requests_taken = 0;
   int scrolls_seen   = 0;
   int clears_sent    = 0;
   int idle_cycles    = 0;
   bit start_high     = 1'b0;
   bit no_idle        = 1'b0;

   text_console_writer_unit #(
      .SCREEN_COLUMNS(COLS),
      .SCREEN_ROWS   (ROWS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_char_code (req_char_code),
      .req_cell_attr (req_cell_attr),
      .req_col       (req_col),
      .req_row       (req_row),
      .rsp_strobe    (rsp_strobe),
      .rsp_cur_col   (rsp_cur_col),
      .rsp_cur_row   (rsp_cur_row),
      .rsp_cursor_pos(rsp_cursor_pos),
      .rsp_read_cell (rsp_read_cell),
      .rsp_scrolled  (rsp_scrolled),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void fill_screen(cell_type value);
      for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = value;
   endfunction

   function automatic cursor_report_type apply_console_command(console_req_type rq);
      int                c;
      int                r;
      logic [15:0]       rd;
      bit                sc;
      cursor_report_type rs;
      c  = (rq.col >= COLS) ? COLS - 1 : int'(rq.col);
      r  = (rq.row >= ROWS) ? ROWS - 1 : int'(rq.row);
      rd = '0;
      sc = 1'b0;
      case (rq.cmd)
         CMD_PUT_CHAR: begin
            case (rq.ch)
               CHAR_NL: begin
                  model_col = 0;
                  cursor_line++;
               end
               CHAR_CR: model_col = 0;
               CHAR_TAB: begin
                  model_col = (model_col + 4) & ~3;
                  if (model_col >= COLS) begin
                     model_col = 0;
                     cursor_line++;
                  end
               end
               CHAR_BS: begin
                  if (model_col > 0) begin
                     model_col--;
                  end else if (cursor_line > 0) begin
                     cursor_line--;
                     model_col = COLS - 1;
                  end
                  screen_cells[cursor_line * COLS + model_col] = {attr_model, BLANK_CHAR};
               end
               default: begin
                  screen_cells[cursor_line * COLS + model_col] = {attr_model, rq.ch};
                  model_col++;
                  if (model_col >= COLS) begin
                     model_col = 0;
                     cursor_line++;
                  end
               end
            endcase
            // Passing the bottom row moves everything up by one line.
            if (cursor_line >= ROWS) begin
               for (int i = 0; i + COLS < CELL_COUNT; i++)
                  screen_cells[i] = screen_cells[i + COLS];
               for (int i = CELL_COUNT - COLS; i < CELL_COUNT; i++)
                  screen_cells[i] = {attr_model, BLANK_CHAR};
               cursor_line = ROWS - 1;
               sc = 1'b1;
            end
         end
         CMD_PUT_AT:  screen_cells[r * COLS + c] = {rq.attr, rq.ch};
         CMD_CLEAR: begin
            fill_screen({attr_model, BLANK_CHAR});
            model_col   = 0;
            cursor_line = 0;
         end
         CMD_SET_CUR: begin
            model_col   = c;
            cursor_line = r;
         end
         CMD_READ:    rd = screen_cells[r * COLS + c];
         default: ;
      endcase
      rs.cur_col   = 7'(model_col);
      rs.cur_row   = 5'(cursor_line);
      rs.pos       = 11'(cursor_line * COLS + model_col);
      rs.read_cell = rd;
      rs.scrolled  = sc;
      return rs;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      cursor_report_type want;
      if (!reset && rsp_strobe) begin
         if (pending_cursor_reports.size() == 0) begin
            $error("result strobe with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_cursor_reports.pop_front();
            compare_field("cur_col", 32'(want.cur_col), 32'(rsp_cur_col));
            compare_field("cur_row", 32'(want.cur_row), 32'(rsp_cur_row));
            compare_field("cursor_pos", 32'(want.pos), 32'(rsp_cursor_pos));
            compare_field("read_cell", 32'(want.read_cell), 32'(rsp_read_cell));
            compare_field("scrolled", 32'(want.scrolled), 32'(rsp_scrolled));
            if (rsp_scrolled) scrolls_seen++;
         end
      end
   end

   // Clear and scroll legitimately hold busy for a full screen sweep.
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("** text_console_writer_unit: FAILED **");
            $finish;
         end
      end
   end

   function automatic int random_gap();
      int pick;
      if (no_idle) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic console_req_type make_request(logic [2:0] cmd, logic [7:0] ch,
                                                    logic [7:0] attr, logic [6:0] col,
                                                    logic [4:0] row);
      console_req_type rq;
      rq.cmd  = cmd;
      rq.ch   = ch;
      rq.attr = attr;
      rq.col  = col;
      rq.row  = row;
      return rq;
   endfunction

   // Mostly in-range positions, with the clamped range still well covered.
   function automatic console_req_type random_request();
      console_req_type rq;
      int              pick;
      rq.ch   = 8'($urandom_range(0, 255));
      rq.attr = 8'($urandom_range(0, 255));
      rq.col  = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, COLS - 1))
                                              : 7'($urandom_range(COLS, 127));
      rq.row  = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, ROWS - 1))
                                              : 5'($urandom_range(ROWS, 31));
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         rq.cmd = CMD_PUT_CHAR;
         if ($urandom_range(0, 99) < 20) begin
            case ($urandom_range(0, 3))
               0:       rq.ch = CHAR_NL;
               1:       rq.ch = CHAR_CR;
               2:       rq.ch = CHAR_TAB;
               default: rq.ch = CHAR_BS;
            endcase
         end
      end else if (pick < 62) rq.cmd = CMD_PUT_AT;
      else if (pick < 74) rq.cmd = CMD_SET_CUR;
      else if (pick < 93) rq.cmd = CMD_READ;
      else if (pick < 94) rq.cmd = CMD_CLEAR;
      else rq.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      return rq;
   endfunction

   task automatic lower_start();
      if (start_high) begin
         start      <= 1'b0;
         start_high  = 1'b0;
      end
   endtask

   task automatic pause_until_drained();
      lower_start();
      @(posedge clock);
      while (pending_cursor_reports.size() != 0) @(posedge clock);
   endtask

   task automatic set_text_attr(logic [7:0] value);
      pause_until_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      attr_model   = value;
   endtask

   // Holds start until the request is taken; start stays high when no gap follows.
   task automatic send_request(console_req_type rq);
      int gap;
      req_cmd       <= rq.cmd;
      req_char_code <= rq.ch;
      req_cell_attr <= rq.attr;
      req_col       <= rq.col;
      req_row       <= rq.row;
      start         <= 1'b1;
      start_high     = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_cursor_reports.push_back(apply_console_command(rq));
      requests_taken++;
      if (rq.cmd == CMD_CLEAR) clears_sent++;
      gap = random_gap();
      if (gap > 0) begin
         lower_start();
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_reset_contents();
      send_request(make_request(CMD_READ, 8'h00, 8'h00, 7'd0, 5'd0));
      send_request(make_request(CMD_READ, 8'hFF, 8'hFF, 7'd127, 5'd31));
   endtask

   task automatic test_control_characters();
      set_text_attr(8'hFF);
      send_request(make_request(CMD_PUT_CHAR, 8'h00, 8'h00, 7'd0, 5'd0));
      send_request(make_request(CMD_PUT_CHAR, 8'hFF, 8'hFF, 7'd127, 5'd31));
      send_request(make_request(CMD_PUT_CHAR, CHAR_TAB, 8'h00, 7'd0, 5'd0));
      send_request(make_request(CMD_PUT_CHAR, CHAR_BS, 8'h00, 7'd0, 5'd0));
      send_request(make_request(CMD_PUT_CHAR, CHAR_CR, 8'h00, 7'd0, 5'd0));
      // Backspace at the top left stays put but still blanks the cell.
      send_request(make_request(CMD_PUT_CHAR, CHAR_BS, 8'h00, 7'd0, 5'd0));
      send_request(make_request(CMD_PUT_CHAR, CHAR_NL, 8'h00, 7'd0, 5'd0));
      send_request(make_request(CMD_PUT_AT, 8'hFF, 8'h00, 7'd127, 5'd31));
      send_request(make_request(CMD_READ, 8'h00, 8'h00, 7'd79, 5'd24));
      send_request(make_request(CMD_SET_CUR, 8'h00, 8'h00, 7'd78, 5'd0));
      send_request(make_request(CMD_PUT_CHAR, CHAR_TAB, 8'h00, 7'd0, 5'd0));
      send_request(make_request(CMD_SET_CUR, 8'h00, 8'h00, 7'd0, 5'd5));
      send_request(make_request(CMD_PUT_CHAR, CHAR_BS, 8'h00, 7'd0, 5'd0));
      send_request(make_request(CMD_READ, 8'h00, 8'h00, 7'd79, 5'd4));
   endtask

   task automatic test_bottom_scroll();
      set_text_attr(8'h00);
      send_request(make_request(CMD_SET_CUR, 8'h00, 8'h00, 7'd127, 5'd31));
      send_request(make_request(CMD_PUT_CHAR, 8'h5A, 8'h00, 7'd0, 5'd0));
      send_request(make_request(CMD_READ, 8'h00, 8'h00, 7'd79, 5'd23));
      send_request(make_request(CMD_SET_CUR, 8'h00, 8'h00, 7'd10, 5'd24));
      send_request(make_request(CMD_PUT_CHAR, CHAR_NL, 8'h00, 7'd0, 5'd0));
      send_request(make_request(CMD_SET_CUR, 8'h00, 8'h00, 7'd76, 5'd24));
      send_request(make_request(CMD_PUT_CHAR, CHAR_TAB, 8'h00, 7'd0, 5'd0));
   endtask

   task automatic test_clear_and_unused();
      set_text_attr(8'h5A);
      send_request(make_request(CMD_CLEAR, 8'hFF, 8'hFF, 7'd127, 5'd31));
      send_request(make_request(CMD_READ, 8'h00, 8'h00, 7'd40, 5'd12));
      send_request(make_request(CMD_UNUSED_LO, 8'hFF, 8'hFF, 7'd127, 5'd31));
      send_request(make_request(CMD_UNUSED_HI, 8'h41, 8'h00, 7'd3, 5'd3));
   endtask

   task automatic test_random_commands(int count);
      set_text_attr(8'($urandom_range(0, 255)));
      for (int i = 0; i < count; i++) begin
         send_request(random_request());
         if (i == count / 2 || $urandom_range(0, 99) == 0) pause_until_drained();
      end
   endtask

   // Runs of text from a cursor placed mostly near the bottom, so that wrap,
   // newline and tab often force a scroll.
   task automatic test_text_bursts(int count);
      console_req_type rq;
      int              sent;
      int              run;
      set_text_attr(8'($urandom_range(0, 255)));
      sent = 0;
      while (sent < count) begin
         no_idle = ($urandom_range(0, 3) == 0);
         rq = random_request();
         rq.cmd = CMD_SET_CUR;
         if ($urandom_range(0, 1) == 1) rq.row = 5'($urandom_range(20, 31));
         send_request(rq);
         run = $urandom_range(5, 20);
         for (int i = 0; i < run; i++) begin
            rq = random_request();
            rq.cmd = CMD_PUT_CHAR;
            if ($urandom_range(0, 99) < 80) rq.ch = 8'($urandom_range(0, 255));
            send_request(rq);
         end
         sent += run + 1;
      end
      no_idle = 1'b0;
   endtask

   task automatic test_back_to_back(int count);
      set_text_attr(8'hFF);
      no_idle = 1'b1;
      for (int i = 0; i < count / 2; i++) send_request(random_request());
      no_idle = 1'b0;
      set_text_attr(8'h00);
      for (int i = 0; i < count / 2; i++) send_request(random_request());
   endtask

   initial begin
      attr_model  = RESET_ATTR;
      model_col   = 0;
      cursor_line = 0;
      fill_screen({RESET_ATTR, BLANK_CHAR});
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_contents();
      test_control_characters();
      test_bottom_scroll();
      test_clear_and_unused();
      test_random_commands(300);
      test_text_bursts(300);
      test_back_to_back(200);
      set_text_attr(RESET_ATTR);
      test_random_commands(20);

      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d requests, including %0d clears, and saw %0d scrolls.",
               requests_taken, clears_sent, scrolls_seen);
      $display("Text attribute was stepped through reset, extreme and random values.");
      if (mismatch_count == 0) begin
         $display("** text_console_writer_unit: PASSED **");
      end else begin
         $display("** text_console_writer_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/tcw_pkg.sv
src/tcw_ram.sv
src/text_console_writer_unit.sv
src/tcw_checker.sv
sim/tb_text_console_writer_unit.sv
